// ===== src/smnp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smnp_pkg
// Types and constants for the strobed mouse nibble port: command codes,
// transaction payloads and phase sequence limits.
// ----------------------------------------------------------------------------
package smnp_pkg;

  typedef enum logic [1:0] {
    CMD_STROBE  = 2'd0,
    CMD_READ    = 2'd1,
    CMD_CONNECT = 2'd2,
    CMD_MOTION  = 2'd3
  } cmd_t;

  typedef logic [2:0] phase_t;

  localparam phase_t     PHASE_IDLE  = 3'd0;
  localparam phase_t     PHASE_LATCH = 3'd2;
  localparam logic [3:0] PHASE_WRAP  = 4'd6;

  typedef struct packed {
    cmd_t              cmd;
    logic [1:0]        target_port;
    logic              com_level;
    logic              enable;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
    logic [1:0]        buttons;
  } in_item_t;

  typedef struct packed {
    logic [3:0] port_nibble;
    logic       trigger_a;
    logic       trigger_b;
    logic       com_echo;
  } out_item_t;

endpackage
`default_nettype wire

// ===== src/strobed_mouse_nibble_port.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// strobed_mouse_nibble_port
// Joystick-port mouse: accumulates motion, steps a strobed phase sequence and
// returns the inverted data nibble plus button and echo bits for every transaction.
// ----------------------------------------------------------------------------
// path from input transaction to result: the input register, then
//   the state update and result register
// throughput: one transaction per cycle; the state update is the
//   only loop, and output backpressure stalls the input register
// reset (rst_n low, synchronous): disconnected, phase 0, counters and latches
//   cleared, port_select 0, no transaction held
module strobed_mouse_nibble_port (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  wire [1:0]            cfg_wdata,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire smnp_pkg::in_item_t in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output smnp_pkg::out_item_t  out_data
);
  import smnp_pkg::*;

  logic [1:0]        port_sel_r;
  logic              in_vld_r;
  in_item_t          in_data_r;
  logic              out_vld_r;
  out_item_t         out_data_r, out_data_nxt;

  phase_t            phase_r, phase_nxt;
  logic signed [7:0] accum_x_r, accum_x_nxt;
  logic signed [7:0] accum_y_r, accum_y_nxt;
  logic [7:0]        latched_x_r, latched_x_nxt;
  logic [7:0]        latched_y_r, latched_y_nxt;
  logic              seen_r, seen_nxt;
  logic              echo_r, echo_nxt;
  logic              conn_r, conn_nxt;
  logic [1:0]        btn_r, btn_nxt;

  logic              fire;
  logic signed [7:0] samp_x, samp_y, conn_x, conn_y;
  logic [3:0]        step_next;
  logic [3:0]        nibble;

  // add a delta and fold back once by 128 when outside +-127
  function automatic logic signed [7:0] fold_add(input logic signed [7:0] a,
                                                 input logic signed [7:0] d);
    logic signed [8:0] s;
    s = {a[7], a} + {d[7], d};
    if (s < -9'sd127) begin
      s = s + 9'sd128;
    end else if (s > 9'sd127) begin
      s = s - 9'sd128;
    end
    return s[7:0];
  endfunction

  assign fire     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || fire;

  assign samp_x    = fold_add(accum_x_r, in_data_r.delta_x);
  assign samp_y    = fold_add(accum_y_r, in_data_r.delta_y);
  assign conn_x    = fold_add(8'sd0, in_data_r.delta_x);
  assign conn_y    = fold_add(8'sd0, in_data_r.delta_y);
  assign step_next = {1'b0, phase_r} + 4'd1;

  always_comb begin
    phase_nxt     = phase_r;
    accum_x_nxt   = accum_x_r;
    accum_y_nxt   = accum_y_r;
    latched_x_nxt = latched_x_r;
    latched_y_nxt = latched_y_r;
    seen_nxt      = seen_r;
    echo_nxt      = echo_r;
    conn_nxt      = conn_r;
    btn_nxt       = btn_r;
    case (in_data_r.cmd)
      CMD_STROBE: begin
        if (in_data_r.target_port == port_sel_r && conn_r) begin
          seen_nxt = in_data_r.com_level;
          if (echo_r != in_data_r.com_level) begin
            if (phase_r == PHASE_IDLE) begin
              if (in_data_r.com_level) begin
                latched_x_nxt = 8'(-samp_x);
                latched_y_nxt = 8'(-samp_y);
                accum_x_nxt   = 8'sd0;
                accum_y_nxt   = 8'sd0;
                phase_nxt     = PHASE_LATCH;
                echo_nxt      = 1'b1;
              end
            end else if (step_next >= PHASE_WRAP) begin
              phase_nxt = PHASE_IDLE;
              echo_nxt  = 1'b0;
            end else begin
              phase_nxt = step_next[2:0];
              echo_nxt  = in_data_r.com_level;
            end
          end
        end
      end
      CMD_READ: begin
        btn_nxt = in_data_r.buttons;
      end
      CMD_CONNECT: begin
        if (in_data_r.enable != conn_r) begin
          phase_nxt     = PHASE_IDLE;
          accum_x_nxt   = conn_x;
          accum_y_nxt   = conn_y;
          latched_x_nxt = 8'd0;
          latched_y_nxt = 8'd0;
          seen_nxt      = !in_data_r.enable;
          echo_nxt      = 1'b0;
          btn_nxt       = 2'd0;
        end
        conn_nxt = in_data_r.enable;
      end
      CMD_MOTION: begin
        accum_x_nxt = samp_x;
        accum_y_nxt = samp_y;
      end
      default: begin
        accum_x_nxt = samp_x;
        accum_y_nxt = samp_y;
      end
    endcase
  end

  // nibble order: y high, x low, x high, y low
  always_comb begin
    case (phase_nxt)
      3'd0:    nibble = latched_y_nxt[7:4];
      3'd1:    nibble = latched_x_nxt[3:0];
      3'd2:    nibble = latched_x_nxt[3:0];
      3'd3:    nibble = latched_x_nxt[7:4];
      3'd4:    nibble = latched_y_nxt[3:0];
      default: nibble = latched_y_nxt[7:4];
    endcase
    out_data_nxt.port_nibble = ~nibble;
    out_data_nxt.trigger_a   = btn_nxt[0];
    out_data_nxt.trigger_b   = btn_nxt[1];
    out_data_nxt.com_echo    = echo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_sel_r  <= 2'd0;
      in_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      phase_r     <= PHASE_IDLE;
      accum_x_r   <= 8'sd0;
      accum_y_r   <= 8'sd0;
      latched_x_r <= 8'd0;
      latched_y_r <= 8'd0;
      seen_r      <= 1'b1;
      echo_r      <= 1'b0;
      conn_r      <= 1'b0;
      btn_r       <= 2'd0;
    end else begin
      if (cfg_we) begin
        port_sel_r <= cfg_wdata;
      end
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (fire) begin
        out_vld_r   <= 1'b1;
        phase_r     <= phase_nxt;
        accum_x_r   <= accum_x_nxt;
        accum_y_r   <= accum_y_nxt;
        latched_x_r <= latched_x_nxt;
        latched_y_r <= latched_y_nxt;
        seen_r      <= seen_nxt;
        echo_r      <= echo_nxt;
        conn_r      <= conn_nxt;
        btn_r       <= btn_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // phase 1 and phase 7 are never entered
  a_phase_reach: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 3'd1 && phase_r != 3'd7)
    else $error("phase counter entered an unreachable phase");

  // folding keeps the counters inside +-127
  a_accum_range: assert property (@(posedge clk) disable iff (!rst_n)
    accum_x_r != -8'sd128 && accum_y_r != -8'sd128)
    else $error("motion counter reached -128");

  // a disconnected mouse sits at phase 0 with the echo low
  a_disc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !conn_r |-> (phase_r == PHASE_IDLE && !echo_r))
    else $error("phase sequence active while disconnected");

  // echo stays low while the phase counter sits at idle
  a_echo_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PHASE_IDLE) |-> !echo_r)
    else $error("echo high at phase 0");

endmodule
`default_nettype wire
